>>> design/kmp_pkg.sv
package kmp_pkg;

    // Sizes of the pattern side and of the text counter.
    localparam int MAX_PATTERN = 32;
    localparam int MAX_TEXT    = 65536;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int TPOS_W      = $clog2(MAX_TEXT);
    localparam int SYM_W       = 8;
    localparam int POS_W       = 16;

    localparam logic [LEN_W-1:0]  PLEN_FULL = LEN_W'(MAX_PATTERN);
    localparam logic [TPOS_W-1:0] TPOS_MAX  = TPOS_W'(MAX_TEXT - 1);

    // Item opcodes and result kinds.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_TEXT    = 1'b1;
    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [SYM_W-1:0] symbol;
        logic             first;
        logic             last;
    } in_beat_t;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] position;
        logic             final_result;
    } out_beat_t;

    // Datapath operations selected by the control word.
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_ACCEPT,
        ACT_L_START,
        ACT_READ,
        ACT_FOLLOW,
        ACT_L_FIN,
        ACT_T_INIT,
        ACT_T_HIT,
        ACT_READ_LINK,
        ACT_SET_LINK,
        ACT_T_END
    } act_t;

    // Jump conditions tested by the sequencer.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_START,
        COND_IS_TEXT,
        COND_PLEN_EDGE,
        COND_NEED_LINK,
        COND_PLEN_ZERO,
        COND_NOT_FULL
    } cond_t;

    typedef logic [3:0] step_t;

    // Program step addresses.
    localparam step_t STEP_IDLE     = 4'd0;
    localparam step_t STEP_DISPATCH = 4'd1;
    localparam step_t STEP_L_START  = 4'd2;
    localparam step_t STEP_RD       = 4'd3;
    localparam step_t STEP_CMP      = 4'd4;
    localparam step_t STEP_EXIT     = 4'd5;
    localparam step_t STEP_L_FIN    = 4'd6;
    localparam step_t STEP_T_INIT   = 4'd7;
    localparam step_t STEP_T_LOOP   = 4'd8;
    localparam step_t STEP_T_HIT    = 4'd9;
    localparam step_t STEP_T_LRD    = 4'd10;
    localparam step_t STEP_T_LSET   = 4'd11;
    localparam step_t STEP_T_END    = 4'd12;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    // Status flags from the datapath to the sequencer.
    typedef struct packed {
        logic is_text;
        logic need_link;
        logic full_match;
        logic plen_edge;
        logic plen_zero;
    } dp_status_t;

    // Control store: one word per program step.
    function automatic ctrl_word_t ucode_word(step_t s);
        ctrl_word_t w;
        case (s)
            STEP_IDLE:     w = '{ACT_ACCEPT,    COND_NO_START,  STEP_IDLE};
            STEP_DISPATCH: w = '{ACT_NONE,      COND_IS_TEXT,   STEP_T_INIT};
            STEP_L_START:  w = '{ACT_L_START,   COND_PLEN_EDGE, STEP_IDLE};
            STEP_RD:       w = '{ACT_READ,      COND_NEVER,     STEP_IDLE};
            STEP_CMP:      w = '{ACT_FOLLOW,    COND_NEED_LINK, STEP_RD};
            STEP_EXIT:     w = '{ACT_NONE,      COND_IS_TEXT,   STEP_T_HIT};
            STEP_L_FIN:    w = '{ACT_L_FIN,     COND_ALWAYS,    STEP_IDLE};
            STEP_T_INIT:   w = '{ACT_T_INIT,    COND_PLEN_ZERO, STEP_T_END};
            STEP_T_LOOP:   w = '{ACT_NONE,      COND_ALWAYS,    STEP_RD};
            STEP_T_HIT:    w = '{ACT_T_HIT,     COND_NOT_FULL,  STEP_T_END};
            STEP_T_LRD:    w = '{ACT_READ_LINK, COND_NEVER,     STEP_IDLE};
            STEP_T_LSET:   w = '{ACT_SET_LINK,  COND_NEVER,     STEP_IDLE};
            STEP_T_END:    w = '{ACT_T_END,     COND_ALWAYS,    STEP_IDLE};
            default:       w = '{ACT_NONE,      COND_ALWAYS,    STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> design/kmp_ram.sv
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/kmp_seq.sv
module kmp_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  kmp_pkg::dp_status_t status,
    output kmp_pkg::ctrl_word_t ctrl,
    output logic                busy
);
    import kmp_pkg::*;

    step_t      step_reg;
    step_t      step_next;
    ctrl_word_t word;
    logic       take;

    // Fetch the control word of the current step.
    assign word = ucode_word(step_reg);
    assign ctrl = word;
    assign busy = (step_reg != STEP_IDLE);

    // Evaluate the jump condition and pick the next step.
    always_comb
    begin
        case (word.cond)
            COND_NEVER:     take = 1'b0;
            COND_ALWAYS:    take = 1'b1;
            COND_NO_START:  take = !start;
            COND_IS_TEXT:   take = status.is_text;
            COND_PLEN_EDGE: take = status.plen_edge;
            COND_NEED_LINK: take = status.need_link;
            COND_PLEN_ZERO: take = status.plen_zero;
            COND_NOT_FULL:  take = !status.full_match;
            default:        take = 1'b1;
        endcase
        step_next = take ? word.target : step_t'(step_reg + 1'b1);
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // The counter stays inside the program.
    a_step_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_T_END)
        else $error("step counter left the program");

    // When the compare step follows a link, the read step comes next.
    a_link_then_read: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_CMP && status.need_link) |=> step_reg == STEP_RD)
        else $error("fallback link not followed by a read");

endmodule

>>> design/kmp_dp.sv
module kmp_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  kmp_pkg::in_beat_t   item,
    input  kmp_pkg::ctrl_word_t ctrl,
    output kmp_pkg::dp_status_t status,
    output logic                result_strobe,
    output kmp_pkg::out_beat_t  result
);
    import kmp_pkg::*;

    in_beat_t          in_reg, in_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [LEN_W-1:0]  plen_reg, plen_next;
    logic [IDX_W-1:0]  build_reg, build_next;
    logic [IDX_W-1:0]  match_reg, match_next;
    logic [TPOS_W-1:0] tpos_reg, tpos_next;
    logic              strobe_reg, strobe_next;
    out_beat_t         res_reg, res_next;

    logic              pat_we;
    logic [SYM_W-1:0]  pat_rdata;
    logic              fail_we;
    logic [IDX_W-1:0]  fail_wdata;
    logic [IDX_W-1:0]  fail_raddr;
    logic [IDX_W-1:0]  fail_rdata;
    logic [IDX_W-1:0]  new_prefix;
    logic [TPOS_W-1:0] start_pos;
    logic              sym_hit;

    // Pattern bytes and failure links.
    kmp_ram #(.WIDTH(SYM_W), .DEPTH(MAX_PATTERN)) u_pattern (
        .clk   (clk),
        .we    (pat_we),
        .waddr (plen_reg[IDX_W-1:0]),
        .wdata (in_reg.symbol),
        .raddr (j_reg),
        .rdata (pat_rdata)
    );

    kmp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PATTERN)) u_failure (
        .clk   (clk),
        .we    (fail_we),
        .waddr (plen_reg[IDX_W-1:0]),
        .wdata (fail_wdata),
        .raddr (fail_raddr),
        .rdata (fail_rdata)
    );

    // Flags for the sequencer.
    assign sym_hit           = (pat_rdata == in_reg.symbol);
    assign status.is_text    = (in_reg.opcode == OP_TEXT);
    assign status.need_link  = (j_reg != '0) && !sym_hit;
    assign status.full_match = sym_hit && (LEN_W'(j_reg) == plen_reg - LEN_W'(1));
    assign status.plen_zero  = (plen_reg == '0);
    assign status.plen_edge  = (plen_reg == '0) || (plen_reg == PLEN_FULL);

    assign new_prefix = sym_hit ? IDX_W'(j_reg + 1'b1) : '0;
    assign start_pos  = tpos_reg + TPOS_W'(1) - TPOS_W'(plen_reg);

    // Operation decode.
    always_comb
    begin
        in_next     = in_reg;
        j_next      = j_reg;
        plen_next   = plen_reg;
        build_next  = build_reg;
        match_next  = match_reg;
        tpos_next   = tpos_reg;
        strobe_next = 1'b0;
        res_next    = res_reg;
        pat_we      = 1'b0;
        fail_we     = 1'b0;
        fail_wdata  = new_prefix;
        fail_raddr  = IDX_W'(j_reg - 1'b1);
        case (ctrl.act)
            ACT_ACCEPT:
            begin
                if (start)
                begin
                    in_next = item;
                    if (item.opcode == OP_LOAD)
                    begin
                        match_next = '0;
                        if (item.first)
                        begin
                            plen_next  = '0;
                            build_next = '0;
                        end
                    end
                    else if (item.first)
                    begin
                        match_next = '0;
                        tpos_next  = '0;
                    end
                end
            end
            ACT_L_START:
            begin
                if (plen_reg == '0)
                begin
                    pat_we     = 1'b1;
                    fail_we    = 1'b1;
                    fail_wdata = '0;
                    build_next = '0;
                    plen_next  = LEN_W'(1);
                end
                else if (plen_reg != PLEN_FULL)
                begin
                    pat_we = 1'b1;
                    j_next = build_reg;
                end
            end
            ACT_FOLLOW:
            begin
                // Links point strictly downward; anything else restarts at zero.
                if (status.need_link)
                begin
                    j_next = (fail_rdata < j_reg) ? fail_rdata : '0;
                end
            end
            ACT_L_FIN:
            begin
                fail_we    = 1'b1;
                build_next = new_prefix;
                plen_next  = LEN_W'(plen_reg + 1'b1);
            end
            ACT_T_INIT:
            begin
                j_next = (LEN_W'(match_reg) >= plen_reg) ? '0 : match_reg;
            end
            ACT_T_HIT:
            begin
                if (status.full_match)
                begin
                    strobe_next           = 1'b1;
                    res_next.kind         = KIND_MATCH;
                    res_next.position     = POS_W'(start_pos);
                    res_next.final_result = !in_reg.last;
                end
                else if (sym_hit)
                begin
                    j_next = IDX_W'(j_reg + 1'b1);
                end
            end
            ACT_READ_LINK:
            begin
                fail_raddr = j_reg;
            end
            ACT_SET_LINK:
            begin
                j_next = fail_rdata;
            end
            ACT_T_END:
            begin
                match_next = j_reg;
                if (tpos_reg != TPOS_MAX)
                begin
                    tpos_next = TPOS_W'(tpos_reg + 1'b1);
                end
                if (in_reg.last)
                begin
                    strobe_next           = 1'b1;
                    res_next.kind         = KIND_END;
                    res_next.position     = '0;
                    res_next.final_result = 1'b1;
                    match_next            = '0;
                    tpos_next             = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg      <= '0;
            plen_reg   <= '0;
            build_reg  <= '0;
            match_reg  <= '0;
            tpos_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            j_reg      <= j_next;
            plen_reg   <= plen_next;
            build_reg  <= build_next;
            match_reg  <= match_next;
            tpos_reg   <= tpos_next;
            strobe_reg <= strobe_next;
        end
    end

    // Captured item and result beat.
    always_ff @(posedge clk)
    begin
        in_reg  <= in_next;
        res_reg <= res_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = res_reg;

    // The pattern never grows past its store.
    a_plen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        plen_reg <= PLEN_FULL)
        else $error("pattern length beyond store depth");

    // A kept partial match is shorter than the pattern or zero.
    a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (LEN_W'(match_reg) < plen_reg) || (match_reg == '0))
        else $error("partial match not below pattern length");

    // Links are only followed from a prefix inside the loaded pattern.
    a_follow_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == ACT_FOLLOW) |-> (LEN_W'(j_reg) < plen_reg))
        else $error("fallback walk outside the pattern");

endmodule

>>> design/kmp_pattern_matcher_top.sv
// Channel   Handshake              Payload            Direction
// item      start high, busy low   in_beat_t item     in
// result    result_strobe          out_beat_t result  out
//
// A pattern byte passes dispatch, start, link loop, exit and finish; the first byte of a
// pattern and a byte into a full pattern stop at start. A text byte passes init, loop,
// link loop, exit, hit and end, with a link read and set after a completed match; an
// empty pattern skips from init to end. The loop over links is one registered read of the
// pattern and link memories and one compare per link. Reset is asynchronous and leaves
// the pattern empty. Each result beat shows for one cycle; the receiver cannot stall it.
module kmp_pattern_matcher_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  kmp_pkg::in_beat_t  item,
    output logic               busy,
    output logic               result_strobe,
    output kmp_pkg::out_beat_t result
);
    import kmp_pkg::*;

    ctrl_word_t ctrl;
    dp_status_t status;

    // Microcode sequencer.
    kmp_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    // Datapath with pattern and link memories.
    kmp_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .item          (item),
        .ctrl          (ctrl),
        .status        (status),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

>>> test/kmp_pattern_matcher_top_test.sv
`timescale 1ns / 100ps

module kmp_pattern_matcher_top_test;
    import kmp_pkg::*;

    // Scoreboard that tracks the matcher's pattern, links and text state and
    // holds the result beats still owed by the block.
    class match_scoreboard;
        logic [SYM_W-1:0] pattern_mem [MAX_PATTERN];
        logic [IDX_W-1:0] link_mem [MAX_PATTERN];
        int unsigned      pat_len;
        int unsigned      build_len;
        int unsigned      match_len;
        int unsigned      text_pos;
        out_beat_t        owed_results [$];
        int               errors;
        int               loads_noted;
        int               texts_noted;
        int               matches_seen;
        int               ends_seen;

        function new();
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                pattern_mem[k] = '0;
                link_mem[k]    = '0;
            end
            pat_len      = 0;
            build_len    = 0;
            match_len    = 0;
            text_pos     = 0;
            errors       = 0;
            loads_noted  = 0;
            texts_noted  = 0;
            matches_seen = 0;
            ends_seen    = 0;
        endfunction

        // Walk the fallback links until the next pattern byte equals c or the prefix is empty.
        function int unsigned follow_links(int unsigned j, logic [SYM_W-1:0] c);
            int unsigned nj;
            while (j > 0 && pattern_mem[j] != c)
            begin
                nj = 32'(link_mem[j-1]);
                j  = (nj < j) ? nj : 0;
            end
            return j;
        endfunction

        // Append one pattern byte and compute its link entry.
        function void load_symbol(in_beat_t b);
            int unsigned i;
            int unsigned j;
            if (b.first)
            begin
                pat_len   = 0;
                build_len = 0;
            end
            match_len = 0;
            i = pat_len;
            if (i >= MAX_PATTERN)
                return;
            pattern_mem[i] = b.symbol;
            if (i == 0)
            begin
                link_mem[0] = '0;
                build_len   = 0;
            end
            else
            begin
                j = follow_links(build_len, b.symbol);
                if (pattern_mem[j] == b.symbol && j < i)
                    j++;
                else
                    j = 0;
                link_mem[i] = IDX_W'(j);
                build_len   = j;
            end
            pat_len = i + 1;
        endfunction

        // Note an accepted input beat and queue the results it must cause.
        function void note_item(in_beat_t b);
            int unsigned      j;
            logic             hit;
            logic [POS_W-1:0] hit_pos;
            out_beat_t        e;
            if (b.opcode == OP_LOAD)
            begin
                loads_noted++;
                load_symbol(b);
                return;
            end
            texts_noted++;
            hit     = 1'b0;
            hit_pos = '0;
            if (b.first)
            begin
                match_len = 0;
                text_pos  = 0;
            end
            if (pat_len > 0)
            begin
                j = (match_len >= pat_len) ? 0 : match_len;
                j = follow_links(j, b.symbol);
                if (pattern_mem[j] == b.symbol)
                begin
                    if (j == pat_len - 1)
                    begin
                        hit     = 1'b1;
                        hit_pos = POS_W'(text_pos + 1 - pat_len);
                        j       = 32'(link_mem[j]);
                    end
                    else
                        j++;
                end
                match_len = j;
            end
            if (text_pos < MAX_TEXT - 1)
                text_pos++;
            if (hit)
            begin
                e.kind         = KIND_MATCH;
                e.position     = hit_pos;
                e.final_result = !b.last;
                owed_results.push_back(e);
            end
            if (b.last)
            begin
                e.kind         = KIND_END;
                e.position     = '0;
                e.final_result = 1'b1;
                owed_results.push_back(e);
                match_len = 0;
                text_pos  = 0;
            end
        endfunction

        // Compare one result beat with the oldest owed result, field by field.
        function void check_result(out_beat_t r);
            out_beat_t e;
            if (owed_results.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with none expected: kind %0d position %0d final %0d",
                         $time, r.kind, r.position, r.final_result);
                return;
            end
            e = owed_results.pop_front();
            if (r.kind == KIND_MATCH)
                matches_seen++;
            else
                ends_seen++;
            if (r.kind !== e.kind)
            begin
                errors++;
                $display("%0t: kind mismatch: expected %0d, actual %0d", $time, e.kind, r.kind);
            end
            if (r.position !== e.position)
            begin
                errors++;
                $display("%0t: position mismatch: expected %0d, actual %0d",
                         $time, e.position, r.position);
            end
            if (r.final_result !== e.final_result)
            begin
                errors++;
                $display("%0t: final_result mismatch: expected %0d, actual %0d",
                         $time, e.final_result, r.final_result);
            end
        endfunction

        function int owed();
            return owed_results.size();
        endfunction
    endclass

    logic            clk;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    in_beat_t        item  = '0;
    logic            busy;
    logic            result_strobe;
    out_beat_t       result;
    match_scoreboard board;
    int              idle_pct = 0;

    kmp_pattern_matcher_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .item          (item),
        .busy          (busy),
        .result_strobe (result_strobe),
        .result        (result)
    );

    // 2 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(20_000_000);
        $display("Run timed out");
        $display("Some tests failed");
        $finish;
    end

    // Result beats are taken at the edge that ends their strobe cycle.
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            board.check_result(result);
    end

    function automatic in_beat_t beat_of(logic op, logic [SYM_W-1:0] s, logic f, logic l);
        in_beat_t b;
        b.opcode = op;
        b.symbol = s;
        b.first  = f;
        b.last   = l;
        return b;
    endfunction

    // Present one beat, hold it until accepted, then maybe leave a gap.
    task automatic send_beat(input in_beat_t b);
        start <= 1'b1;
        item  <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_item(b);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
        end
    endtask

    // Stop sending until every owed result has arrived, then let a
    // resultless pattern load run out.
    task automatic drain();
        start <= 1'b0;
        for (int w = 0; w < 20000 && board.owed() > 0; w++)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
    endtask

    // Load a pattern over a small alphabet, then scan one to three texts, some built to hit it.
    task automatic load_and_scan();
        logic [SYM_W-1:0] alph [3];
        logic [SYM_W-1:0] pat [36];
        int               n_alph;
        int               plen;
        int               tlen;
        int               offs;
        int               r;
        logic [SYM_W-1:0] s;
        n_alph = $urandom_range(1, 3);
        for (int k = 0; k < 3; k++)
            alph[k] = SYM_W'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 75)
            plen = $urandom_range(1, 6);
        else if (r < 95)
            plen = $urandom_range(7, MAX_PATTERN);
        else
            plen = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 4);
        for (int k = 0; k < plen; k++)
        begin
            pat[k] = alph[$urandom_range(0, n_alph - 1)];
            send_beat(beat_of(OP_LOAD, pat[k],
                              (k == 0) && ($urandom_range(0, 99) < 95),
                              $urandom_range(0, 99) < 10));
        end
        if (plen > MAX_PATTERN)
            plen = MAX_PATTERN;
        repeat ($urandom_range(1, 3))
        begin
            tlen = $urandom_range(1, 2 * plen + 10);
            offs = $urandom_range(0, plen - 1);
            r    = $urandom_range(0, 1);
            for (int k = 0; k < tlen; k++)
            begin
                if (r == 0 || $urandom_range(0, 99) < 10)
                    s = alph[$urandom_range(0, n_alph - 1)];
                else
                    s = pat[(k + offs) % plen];
                send_beat(beat_of(OP_TEXT, s,
                                  (k == 0) && ($urandom_range(0, 99) < 90),
                                  (k == tlen - 1) && ($urandom_range(0, 99) < 90)));
            end
        end
    endtask

    // Text of arbitrary bytes with scattered start and end flags.
    task automatic scan_noisy();
        int tlen;
        tlen = $urandom_range(1, 30);
        for (int k = 0; k < tlen; k++)
            send_beat(beat_of(OP_TEXT, SYM_W'($urandom_range(0, 255)),
                              $urandom_range(0, 99) < 20, $urandom_range(0, 99) < 15));
    endtask

    // Fully random beats: loads in mid-text, stray flags and so on.
    task automatic noise_burst();
        repeat ($urandom_range(1, 8))
            send_beat(beat_of(1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)),
                              $urandom_range(0, 99) < 30, $urandom_range(0, 99) < 30));
    endtask

    initial
    begin
        int idle_plan [4];
        int target;
        int r;
        idle_plan = '{0, 65, 0, 15};
        board = new();
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Text with an empty pattern gives only end-of-text beats, and a text
        // byte right after an end starts a new text.
        send_beat(beat_of(OP_TEXT, 8'h00, 1'b1, 1'b0));
        send_beat(beat_of(OP_TEXT, 8'hFF, 1'b0, 1'b1));
        send_beat(beat_of(OP_TEXT, 8'hA5, 1'b0, 1'b0));
        send_beat(beat_of(OP_TEXT, 8'h5A, 1'b0, 1'b1));

        // The last flag on a load does nothing; a text without a start flag
        // continues from position zero after the previous end.
        send_beat(beat_of(OP_LOAD, 8'h00, 1'b1, 1'b1));
        send_beat(beat_of(OP_LOAD, 8'hFF, 1'b0, 1'b0));
        send_beat(beat_of(OP_TEXT, 8'h00, 1'b0, 1'b0));
        send_beat(beat_of(OP_TEXT, 8'hFF, 1'b0, 1'b0));
        send_beat(beat_of(OP_TEXT, 8'h00, 1'b0, 1'b0));
        send_beat(beat_of(OP_TEXT, 8'hFF, 1'b0, 1'b0));
        send_beat(beat_of(OP_TEXT, 8'h00, 1'b0, 1'b1));

        // Overlapping matches; the final byte completes a match and ends the text.
        for (int k = 0; k < 3; k++)
            send_beat(beat_of(OP_LOAD, 8'h3C, k == 0, 1'b0));
        for (int k = 0; k < 5; k++)
            send_beat(beat_of(OP_TEXT, 8'h3C, k == 0, k == 4));

        // A new pattern loaded in the middle of a text drops the partial match.
        send_beat(beat_of(OP_TEXT, 8'h3C, 1'b1, 1'b0));
        send_beat(beat_of(OP_TEXT, 8'h3C, 1'b0, 1'b0));
        send_beat(beat_of(OP_LOAD, 8'h81, 1'b1, 1'b0));
        send_beat(beat_of(OP_TEXT, 8'h81, 1'b0, 1'b1));
        drain();

        // Random phases with different sender gap rates; the block is drained
        // between phases.
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = idle_plan[p];
            target   = board.loads_noted + board.texts_noted + 410;
            while (board.loads_noted + board.texts_noted < target)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    load_and_scan();
                else if (r < 85)
                    scan_noisy();
                else
                    noise_burst();
            end
            drain();
        end

        if (board.owed() > 0)
        begin
            board.errors++;
            $display("%0t: %0d expected result beats never arrived", $time, board.owed());
        end
        $display("Sent %0d pattern bytes and %0d text bytes;",
                 board.loads_noted, board.texts_noted);
        $display("checked %0d matches and %0d text ends over empty, short and full patterns.",
                 board.matches_seen, board.ends_seen);
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
